[sv/sca_pkg.sv]
// Shared types, constants and the unit conversion for the strip chart autoscaler.
package sca_pkg;

  localparam int CHANNELS      = 4;
  localparam int HISTORY_DEPTH = 100;
  localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [15:0] INVALID_CODE = 16'sd32760;
  localparam logic signed [15:0] KELVIN_OFS   = 16'sd2732;
  localparam logic signed [15:0] FAHR_OFS     = 16'sd320;
  localparam logic [16:0]        RECIP_10     = 17'd52429;  // 2^19 / 10, rounded up
  localparam logic [16:0]        RECIP_5      = 17'd52429;  // 2^18 / 5, rounded up

  localparam logic [1:0] UNIT_C = 2'd0;
  localparam logic [1:0] UNIT_F = 2'd1;
  localparam logic [1:0] UNIT_K = 2'd2;

  localparam logic REG_UNIT = 1'b0;
  localparam logic REG_SEL  = 1'b1;

  localparam logic [2:0] SEL_ALL = 3'd4;

  // scan control, aligned with the lane memory read data
  typedef struct packed {
    logic clear;
    logic en;
    logic hit;   // address is the newest row
    logic vld;   // row has been written since reset
  } scan_t;

  typedef struct packed {
    logic               vld;
    logic signed [15:0] value;
    logic [7:0]         row;
  } lane_res_t;

  typedef struct packed {
    logic               any;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } lane_mm_t;

  typedef struct packed {
    logic signed [15:0] amin;
    logic signed [15:0] amax;
    logic [10:0]        scale;
    logic [2:0]         digits;
    logic [7:0]         pts;
  } merge_res_t;

  // tenths of degree C to the display unit, 16-bit wrap
  function automatic logic signed [15:0] to_unit(input logic signed [15:0] c,
                                                 input logic [1:0] unit);
    logic signed [15:0] t;
    logic [16:0]        mag;
    logic [33:0]        prod;
    logic [16:0]        q;
    logic [15:0]        sq;
    t    = $signed({c[11:0], 4'b0} + {c[14:0], 1'b0});
    mag  = t[15] ? 17'(-{t[15], t}) : {1'b0, t};
    prod = mag * RECIP_10;
    q    = {2'b0, prod[33:19]};
    sq   = t[15] ? 16'(-q) : q[15:0];
    case (unit)
      UNIT_F:  to_unit = $signed(sq + FAHR_OFS);
      UNIT_K:  to_unit = c + KELVIN_OFS;
      default: to_unit = c;
    endcase
  endfunction

endpackage

[sv/sca_div.sv]
// Restoring divider, one quotient bit per cycle, for the pixel row offset.
module sca_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [10:0] divisor,
  output logic [15:0] quotient,
  output logic        done
);

  logic        busy;
  logic [3:0]  cnt;
  logic [10:0] rem;
  logic [11:0] rs;
  logic        fits;

  assign rs   = {rem, quotient[15]};
  assign fits = rs >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[14:0], fits};
      rem      <= fits ? 11'(rs - {1'b0, divisor}) : rs[10:0];
    end
  end

endmodule

[sv/sca_lane.sv]
// One channel lane: history memory, conversion, min/max scan and row divide.
module sca_lane #(
  parameter int HISTORY_DEPTH = sca_pkg::HISTORY_DEPTH,
  parameter int AW = $clog2(HISTORY_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          unit,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic [AW-1:0]       rd_addr,
  input  sca_pkg::scan_t      scan,
  input  logic                div_start,
  input  logic signed [15:0]  amin,
  input  logic [10:0]         scale,
  output sca_pkg::lane_mm_t   mm,
  output sca_pkg::lane_res_t  res,
  output logic                div_done
);

  logic signed [15:0] mem [HISTORY_DEPTH];
  logic signed [15:0] rdata;
  logic signed [15:0] cv;
  logic               c_en, c_hit, c_ok;
  logic signed [15:0] lat_val;
  logic               lat_vld;
  logic [15:0]        quo;
  logic [15:0]        dvd;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  // convert stage
  always_ff @(posedge clk) begin
    if (rst) begin
      c_en <= 1'b0;
    end else begin
      c_en <= scan.en;
    end
    c_hit <= scan.hit;
    c_ok  <= scan.vld && (rdata != sca_pkg::INVALID_CODE);
    cv    <= sca_pkg::to_unit(rdata, unit);
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst || scan.clear) begin
      mm.any  <= 1'b0;
      lat_vld <= 1'b0;
    end else if (c_en) begin
      if (c_ok) begin
        mm.any <= 1'b1;
        if (!mm.any || cv < mm.lo) mm.lo <= cv;
        if (!mm.any || cv > mm.hi) mm.hi <= cv;
      end
      if (c_hit) lat_vld <= c_ok;
    end
    if (c_en && c_hit) lat_val <= cv;
  end

  assign dvd = lat_vld ? 16'(lat_val - amin) : 16'd0;

  sca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (scale),
    .quotient (quo),
    .done     (div_done)
  );

  assign res.vld   = lat_vld;
  assign res.value = lat_vld ? lat_val : 16'sd0;
  assign res.row   = lat_vld ? 8'(8'd60 - quo[7:0]) : 8'd0;

endmodule

[sv/sca_merge.sv]
// Merges lane min/max and derives axis range, scale, digit count and points.
module sca_merge #(
  parameter int HISTORY_DEPTH = sca_pkg::HISTORY_DEPTH,
  parameter int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  sca_pkg::lane_mm_t    mm [sca_pkg::CHANNELS],
  input  logic [CW-1:0]        points_held,
  output sca_pkg::merge_res_t  res,
  output logic                 done
);

  logic               v1, v2;
  logic signed [15:0] glo, ghi, lo2, hi2, amax2;
  logic [16:0]        delta;
  logic [10:0]        sc2;
  logic               g_any;
  logic signed [15:0] c_lo, c_hi;
  logic [16:0]        x;
  logic [30:0]        prod;
  logic [10:0]        sc3;
  logic signed [17:0] hs;
  logic [2:0]         dg;
  logic [CW-1:0]      lim;

  always_comb begin
    g_any = 1'b0;
    c_lo  = 16'sd0;
    c_hi  = 16'sd0;
    for (int i = 0; i < sca_pkg::CHANNELS; i++) begin
      if (mm[i].any) begin
        if (!g_any || mm[i].lo < c_lo) c_lo = mm[i].lo;
        if (!g_any || mm[i].hi > c_hi) c_hi = mm[i].hi;
        g_any = 1'b1;
      end
    end
  end

  assign x    = 17'(delta + 17'd39);
  assign prod = x[16:3] * sca_pkg::RECIP_5;
  assign sc3  = (sc2 == 11'd0) ? 11'd1 : sc2;
  assign hs   = 18'(hi2) + $signed({5'b0, sc3, 2'b0});

  always_comb begin
    if (lo2 < -16'sd999 || hs > 18'sd9999) dg = 3'd4;
    else if (lo2 < -16'sd100 || hs > 18'sd999) dg = 3'd3;
    else dg = 3'd2;
    lim = CW'(HISTORY_DEPTH) - CW'(5 * (dg - 3'd2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
    glo   <= c_lo;
    ghi   <= c_hi;
    delta <= 17'(18'(ghi) - 18'(glo));
    lo2   <= glo;
    hi2   <= ghi;
    amax2 <= (18'(ghi) - 18'(glo) < 18'd4) ? glo + 16'sd4 : ghi;
    if (v1) sc2 <= 11'(prod[30:18]);
    if (v2) begin
      res.amin   <= lo2;
      res.amax   <= amax2;
      res.scale  <= sc3;
      res.digits <= dg;
      res.pts    <= 8'((lim < points_held) ? lim : points_held);
    end
  end

endmodule

[sv/strip_chart_autoscaler.sv]
// Strip chart autoscaler top level: control sequencer, lanes and merge.
// Results leave one per cycle when out_ready is held high, four per sample set.
// A new sample set is taken only in the idle state, after all four results of
// the previous set are accepted; the memory scan reads one history row per cycle
// in each channel lane.
// Reset (rst, synchronous) marks all history rows unwritten, so they read as
// invalid; position, count and registers return to their reset values.
module strip_chart_autoscaler #(
  parameter int HISTORY_DEPTH = sca_pkg::HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample_ch0,
  input  logic signed [15:0] sample_ch1,
  input  logic signed [15:0] sample_ch2,
  input  logic signed [15:0] sample_ch3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         channel,
  output logic               shown,
  output logic signed [15:0] latest_value,
  output logic [7:0]         latest_row,
  output logic signed [15:0] axis_min,
  output logic signed [15:0] axis_max,
  output logic [10:0]        scale,
  output logic [2:0]         axis_digits,
  output logic [6:0]         points_shown,
  output logic               last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int NCH = sca_pkg::CHANNELS;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_MERGE, S_DIV, S_OUT} state_t;

  state_t         state;
  logic [1:0]     unit;
  logic [2:0]     sel;
  logic [AW-1:0]  wp, wp_next, addr;
  logic [CW-1:0]  held;
  logic [HISTORY_DEPTH-1:0] rowv;
  logic [1:0]     wait_cnt;
  logic [sca_pkg::CH_W-1:0] idx;
  logic           merge_start, div_start;
  logic           merge_done;
  logic           in_acc, out_acc;
  sca_pkg::scan_t scan;

  logic signed [15:0]   samples [NCH];
  logic                 div_done [NCH];
  sca_pkg::lane_mm_t    mm  [NCH];
  sca_pkg::lane_res_t   lres [NCH];
  sca_pkg::merge_res_t  mres;

  assign samples[0] = sample_ch0;
  assign samples[1] = sample_ch1;
  assign samples[2] = sample_ch2;
  assign samples[3] = sample_ch3;

  // no request is taken while reset is held
  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // write position steps down with wrap
  assign wp_next = (wp == '0 || 32'(wp) >= HISTORY_DEPTH) ? AW'(HISTORY_DEPTH - 1)
                                                          : AW'(wp - 1'b1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= sca_pkg::UNIT_C;
      sel  <= sca_pkg::SEL_ALL;
    end else if (cfg_we) begin
      case (cfg_index)
        sca_pkg::REG_UNIT: unit <= cfg_data[1:0];
        sca_pkg::REG_SEL:  sel  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: store, scan every row, merge, divide, then hand out results
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wp          <= '0;
      held        <= '0;
      rowv        <= '0;
      addr        <= '0;
      wait_cnt    <= '0;
      idx         <= '0;
      scan        <= '0;
      merge_start <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      scan        <= '0;
      merge_start <= 1'b0;
      div_start   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            wp            <= wp_next;
            rowv[wp_next] <= 1'b1;
            if (32'(held) < HISTORY_DEPTH) held <= held + 1'b1;
            addr       <= '0;
            scan.clear <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan.en  <= 1'b1;
          scan.hit <= (addr == wp);
          scan.vld <= rowv[addr];
          if (addr == AW'(HISTORY_DEPTH - 1)) begin
            wait_cnt <= '0;
            state    <= S_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_DRAIN: begin
          // read, convert and accumulate stages empty out
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == 2'd2) begin
            merge_start <= 1'b1;
            state       <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_done) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done[0]) begin
            idx   <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (32'(idx) == NCH - 1) state <= S_IDLE;
            else idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    sca_lane #(.HISTORY_DEPTH(HISTORY_DEPTH), .AW(AW)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .unit      (unit),
      .wr_en     (in_acc),
      .wr_addr   (wp_next),
      .wr_data   (samples[g]),
      .rd_addr   (addr),
      .scan      (scan),
      .div_start (div_start),
      .amin      (mres.amin),
      .scale     (mres.scale),
      .mm        (mm[g]),
      .res       (lres[g]),
      .div_done  (div_done[g])
    );
  end

  sca_merge #(.HISTORY_DEPTH(HISTORY_DEPTH), .CW(CW)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .start       (merge_start),
    .mm          (mm),
    .points_held (held),
    .res         (mres),
    .done        (merge_done)
  );

  // result fields; channel selection: codes 4 and up show every channel
  assign channel      = 2'(idx);
  assign shown        = lres[idx].vld && (sel >= sca_pkg::SEL_ALL || sel == 3'(idx));
  assign latest_value = lres[idx].value;
  assign latest_row   = lres[idx].row;
  assign axis_min     = mres.amin;
  assign axis_max     = mres.amax;
  assign scale        = mres.scale;
  assign axis_digits  = mres.digits;
  assign points_shown = mres.pts[6:0];
  assign last         = (32'(idx) == NCH - 1);

endmodule

[test/strip_chart_autoscaler_tb.sv]
// Self-checking testbench for the strip chart autoscaler: predicted results per sample set.
`timescale 1ns / 1ps

module strip_chart_autoscaler_tb;

  typedef struct packed {
    logic signed [15:0] t0;
    logic signed [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
  } sample_set_t;

  typedef struct packed {
    logic [1:0]         chn;
    logic               shw;
    logic signed [15:0] val;
    logic [7:0]         row;
    logic signed [15:0] amin;
    logic signed [15:0] amax;
    logic [10:0]        scl;
    logic [2:0]         dig;
    logic [6:0]         pts;
    logic               lst;
  } chart_row_t;

  localparam int MAX_CYCLES = 400000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] sample_ch0 = '0, sample_ch1 = '0, sample_ch2 = '0, sample_ch3 = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         channel;
  logic               shown;
  logic signed [15:0] latest_value;
  logic [7:0]         latest_row;
  logic signed [15:0] axis_min, axis_max;
  logic [10:0]        scale;
  logic [2:0]         axis_digits;
  logic [6:0]         points_shown;
  logic               last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [2:0]         cfg_data = '0;

  strip_chart_autoscaler dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] hist [sca_pkg::CHANNELS][sca_pkg::HISTORY_DEPTH];
  int                 wpos, held;
  logic [1:0]         unit_q;
  logic [2:0]         sel_q;

  sample_set_t pending_sets[$];
  chart_row_t  expected_rows[$];
  int          errors, sent, got, cycles;
  int          send_idle_pct, recv_idle_pct;

  task automatic report(input string what, input chart_row_t g, input chart_row_t e);
    errors++;
    $display("MISMATCH %s: got %p exp %p", what, g, e);
  endtask

  function automatic int convert(input int c);
    int t;
    if (unit_q == sca_pkg::UNIT_F) begin
      t = int'(16'(c * 18));
      t = t / 10;
      return int'($signed(16'(t + 320)));
    end
    if (unit_q == sca_pkg::UNIT_K) return int'($signed(16'(c + 2732)));
    return c;
  endfunction

  // store one set, rescan the history and queue four expected rows
  task automatic predict_chart(input sample_set_t s);
    int lo, hi, amin, amax, delta, scl, dig, lim, pts, raw, v, off;
    bit any;
    chart_row_t r;
    lo = 0; hi = 0; any = 0;
    wpos = (wpos == 0) ? sca_pkg::HISTORY_DEPTH - 1 : wpos - 1;
    if (held < sca_pkg::HISTORY_DEPTH) held++;
    hist[0][wpos] = s.t0; hist[1][wpos] = s.t1;
    hist[2][wpos] = s.t2; hist[3][wpos] = s.t3;
    for (int c = 0; c < sca_pkg::CHANNELS; c++)
      for (int i = 0; i < sca_pkg::HISTORY_DEPTH; i++) begin
        raw = hist[c][i];
        if (raw != sca_pkg::INVALID_CODE) begin
          v = convert(raw);
          if (!any) begin
            lo = v; hi = v; any = 1;
          end else begin
            if (v > hi) hi = v;
            if (v < lo) lo = v;
          end
        end
      end
    amin = lo; amax = hi; delta = hi - lo;
    if (delta < 4) amax = int'($signed(16'(amin + 4)));
    scl = (delta + 39) / 40;
    if (scl == 0) scl = 1;
    dig = 2;
    if (lo < -999 || hi + scl * 4 > 9999) dig = 4;
    else if (lo < -100 || hi + scl * 4 > 999) dig = 3;
    pts = held;
    lim = sca_pkg::HISTORY_DEPTH - (dig - 2) * 5;
    if (lim < pts) pts = lim;
    for (int c = 0; c < sca_pkg::CHANNELS; c++) begin
      raw = hist[c][wpos];
      r = '0;
      r.chn = 2'(c);
      if (raw != sca_pkg::INVALID_CODE) begin
        v = convert(raw);
        off = ((v - amin) & 32'hFFFF) / scl;
        r.val = 16'(v);
        r.row = 8'(60 - off);
        r.shw = (sel_q >= sca_pkg::SEL_ALL) || (sel_q == c);
      end
      r.amin = 16'(amin); r.amax = 16'(amax); r.scl = 11'(scl);
      r.dig = 3'(dig); r.pts = 7'(pts);
      r.lst = (c == sca_pkg::CHANNELS - 1);
      expected_rows.push_back(r);
    end
  endtask

  // driver: hold the request until the handshake, then maybe idle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_chart({sample_ch0, sample_ch1, sample_ch2, sample_ch3});
        sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_set_t s;
          s = pending_sets.pop_front();
          in_valid   <= 1'b1;
          sample_ch0 <= s.t0; sample_ch1 <= s.t1;
          sample_ch2 <= s.t2; sample_ch3 <= s.t3;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        chart_row_t g, e;
        g = {channel, shown, latest_value, latest_row, axis_min, axis_max,
             scale, axis_digits, points_shown, last};
        got++;
        if (expected_rows.size() == 0) report("unexpected result", g, g);
        else begin
          e = expected_rows.pop_front();
          if (g.chn  !== e.chn)  report("channel", g, e);
          if (g.shw  !== e.shw)  report("shown", g, e);
          if (g.val  !== e.val)  report("latest_value", g, e);
          if (g.row  !== e.row)  report("latest_row", g, e);
          if (g.amin !== e.amin) report("axis_min", g, e);
          if (g.amax !== e.amax) report("axis_max", g, e);
          if (g.scl  !== e.scl)  report("scale", g, e);
          if (g.dig  !== e.dig)  report("axis_digits", g, e);
          if (g.pts  !== e.pts)  report("points_shown", g, e);
          if (g.lst  !== e.lst)  report("last", g, e);
        end
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_temp();
    case ($urandom_range(9))
      0:       return sca_pkg::INVALID_CODE;
      1:       return 16'($urandom());             // full range, every bit
      2:       return $signed(16'($urandom_range(0, 65535)));
      3:       return 16'sd32767 - 16'($urandom_range(20));
      4:       return -16'sd32768 + 16'($urandom_range(20));
      default: return 16'($signed($urandom_range(0, 1600)) - 400);
    endcase
  endfunction

  task automatic queue_random(input int n);
    sample_set_t s;
    repeat (n) begin
      s.t0 = rand_temp(); s.t1 = rand_temp(); s.t2 = rand_temp(); s.t3 = rand_temp();
      pending_sets.push_back(s);
    end
  endtask

  // drain everything, then give the block time to settle before a write
  task automatic wait_idle();
    while (pending_sets.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (sca_pkg::HISTORY_DEPTH + 40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] data);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sca_pkg::REG_UNIT) unit_q = data[1:0];
    else sel_q = data;
    @(posedge clk);
  endtask

  initial begin
    sample_set_t s;
    errors = 0; sent = 0; got = 0; cycles = 0;
    wpos = 0; held = 0; unit_q = sca_pkg::UNIT_C; sel_q = sca_pkg::SEL_ALL;
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int c = 0; c < sca_pkg::CHANNELS; c++)
      for (int i = 0; i < sca_pkg::HISTORY_DEPTH; i++) hist[c][i] = sca_pkg::INVALID_CODE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-store case, extremes, converted-to-invalid-code value
    s = {sca_pkg::INVALID_CODE, sca_pkg::INVALID_CODE, sca_pkg::INVALID_CODE,
         sca_pkg::INVALID_CODE};                                   pending_sets.push_back(s);
    s = {16'sd0, 16'sd1, 16'sd2, sca_pkg::INVALID_CODE};          pending_sets.push_back(s);
    s = {16'sd32767, -16'sd32768, 16'sd32759, 16'sd32761};         pending_sets.push_back(s);
    s = {16'sd30028, -16'sd1, 16'sd1000, -16'sd999};               pending_sets.push_back(s);
    wait_idle();
    write_reg(sca_pkg::REG_UNIT, {1'b0, sca_pkg::UNIT_F});
    write_reg(sca_pkg::REG_SEL, 3'd0);
    s = {-16'sd100, 16'sd250, sca_pkg::INVALID_CODE, 16'sd18204};  pending_sets.push_back(s);
    s = {-16'sd32768, 16'sd32767, 16'sd5, -16'sd5};                pending_sets.push_back(s);
    wait_idle();
    write_reg(sca_pkg::REG_UNIT, {1'b0, sca_pkg::UNIT_K});
    write_reg(sca_pkg::REG_SEL, 3'd3);
    s = {16'sd0, -16'sd2732, 16'sd30028, sca_pkg::INVALID_CODE};   pending_sets.push_back(s);
    s = {16'sd32767, -16'sd32768, 16'sd100, 16'sd100};             pending_sets.push_back(s);
    wait_idle();
    write_reg(sca_pkg::REG_UNIT, 3'd3);   // unused code behaves as Celsius
    write_reg(sca_pkg::REG_SEL, 3'd7);    // out-of-range selection shows all
    s = {16'sd10, 16'sd11, 16'sd12, 16'sd13};                      pending_sets.push_back(s);
    wait_idle();

    // random phases: receiver-heavy idle, sender-heavy idle, none
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sca_pkg::REG_UNIT, 3'($urandom_range(3)));
      write_reg(sca_pkg::REG_SEL, 3'($urandom_range(7)));
      send_idle_pct = (ph < 2) ? 37 : (ph < 4) ? 55 : 0;
      recv_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 37 : 0;
      queue_random(45);
      wait_idle();
    end

    $display("Covered %0d sample sets, %0d results, all units and selections,", sent, got);
    $display("history wrap past depth %0d, with idle on both sides.",
             sca_pkg::HISTORY_DEPTH);
    if (errors == 0 && expected_rows.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
